### sv/tts_pkg.sv
// Package for the tick task scheduler table.
// Holds the action, status and state codes and the request payload types.
// No dependencies.
package tts_pkg;

    // Action codes carried by an input request.
    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_ADD      = 2'd1,
        ACT_DELETE   = 2'd2,
        ACT_DISPATCH = 2'd3
    } t_action;

    // Status codes carried by a result request.
    localparam logic [1:0] STAT_ADDED = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_DUE   = 2'd2;

    // Saturation limit of the pending-run count.
    localparam logic [7:0] PEND_MAX = 8'hFF;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADD_WAIT,
        ST_FLUSH
    } t_state;

    // Input request payload.
    typedef struct packed {
        t_action     action;
        logic [7:0]  task_tag;
        logic [15:0] first_delay;
        logic [15:0] repeat_period;
        logic [2:0]  slot_index;
    } t_in_item;

    // Result request payload.
    typedef struct packed {
        logic [1:0] status;
        logic [2:0] slot;
        logic [7:0] due_tag;
        logic       last;
    } t_out_item;

endpackage

### sv/tts_stream_if.sv
// Valid/ready stream interface used by the scheduler channels.
// The payload type is a parameter; no other dependencies.
interface tts_stream_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/tts_slot_update.sv
// Per-slot modify step of the scheduler read-modify-write scan.
// Computes the new delay and pending count of one slot for tick or dispatch.
// Depends on tts_pkg.
module tts_slot_update #(
    parameter int TIME_BITS = 16
) (
    input  logic                 i_dispatch,
    input  logic                 i_occupied,
    input  logic [TIME_BITS-1:0] i_delay,
    input  logic [TIME_BITS-1:0] i_period,
    input  logic [7:0]           i_pending,
    output logic [TIME_BITS-1:0] o_delay,
    output logic [7:0]           o_pending,
    output logic                 o_due
);

    localparam logic [TIME_BITS-1:0] ONE = {{(TIME_BITS-1){1'b0}}, 1'b1};

    // Free slots pass through unchanged; occupied slots count down or fire.
    always_comb begin
        o_delay   = i_delay;
        o_pending = i_pending;
        o_due     = 1'b0;
        if (i_occupied) begin
            if (i_dispatch) begin
                if (i_pending != 8'd0) begin
                    o_pending = i_pending - 8'd1;
                    o_due     = 1'b1;
                end
            end else if (i_delay != '0) begin
                o_delay = i_delay - ONE;
            end else begin
                if (i_period != '0) begin
                    o_delay = i_period;
                end
                if (i_pending != tts_pkg::PEND_MAX) begin
                    o_pending = i_pending + 8'd1;
                end
            end
        end
    end

endmodule

### sv/tick_task_scheduler_table.sv
// Tick task scheduler table, top level.
// Depends on tts_pkg, tts_stream_if and tts_slot_update.
//
// Usage: requests enter on i_in (action, task_tag, first_delay, repeat_period,
// slot_index) and results leave on o_out (status, slot, due_tag, last). Both
// channels use valid/ready; a request moves when both are high.
// The slot table sits in one synchronous memory with a registered read port;
// the occupied marks are flip-flops. Tick and dispatch walk the table one slot
// per cycle, unless a dispatch stalls on the receiver, as a read-modify-write
// pipeline: the data of slot k is modified and written back while slot k+1
// is read. A tick scans every slot and gives no result; a dispatch scans it
// and then flushes any held due slot; an add writes its slot on acceptance
// and loads its result into the output register in ST_ADD_WAIT; a delete
// clears its mark on acceptance. The next request is taken once the current
// one is done, while an earlier result may still wait. Dispatch holds each
// due slot back by one so the final one carries last. If the receiver stalls,
// the scan pauses on the current slot and resumes. Reset clears the occupied
// marks, which empties the table; the memory itself needs no clearing.
module tick_task_scheduler_table #(
    parameter int SLOTS     = 8,
    parameter int TIME_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tts_stream_if.sink   i_in,
    tts_stream_if.source o_out
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);
    localparam logic [6:0]        SLOTS_7  = 7'(SLOTS);

    typedef struct packed {
        logic [7:0]           tag;
        logic [TIME_BITS-1:0] delay;
        logic [TIME_BITS-1:0] period;
        logic [7:0]           pending;
    } t_entry;

    // Slot table memory.
    t_entry r_mem [SLOTS];
    t_entry r_rd_data;

    // Control and payload registers.
    tts_pkg::t_state    r_state, n_state;
    logic [SLOTS-1:0]   r_occ;
    logic [SLOT_W-1:0]  r_idx;
    logic               r_is_disp;
    logic [1:0]         r_add_status;
    logic [2:0]         r_add_slot;
    logic               r_hold_valid;
    logic [2:0]         r_hold_slot;
    logic [7:0]         r_hold_tag;
    logic               r_out_valid;
    tts_pkg::t_out_item r_out;

    // Combinational control.
    logic               w_accept;
    logic               w_out_free;
    logic               w_found;
    logic [SLOT_W-1:0]  w_free;
    logic [SLOT_W-1:0]  w_rd_addr;
    logic               w_we;
    logic [SLOT_W-1:0]  w_wa;
    t_entry             w_wd;
    logic               w_due;
    logic               w_stall;
    logic               w_scan_step;
    logic               w_out_load;
    tts_pkg::t_out_item w_out_data;
    logic [TIME_BITS-1:0] w_upd_delay;
    logic [7:0]         w_upd_pend;
    logic               w_upd_due;
    logic [31:0]        w_delay_ext;
    logic [31:0]        w_period_ext;
    logic [6:0]         w_del_idx;
    logic [6:0]         w_idx_ext;
    logic [6:0]         w_free_ext;

    assign w_out_free   = !r_out_valid || o_out.ready;
    assign w_accept     = i_in.valid && (r_state == tts_pkg::ST_IDLE);
    assign w_delay_ext  = 32'(i_in.data.first_delay);
    assign w_period_ext = 32'(i_in.data.repeat_period);
    assign w_del_idx    = 7'(i_in.data.slot_index);
    assign w_idx_ext    = 7'(r_idx);
    assign w_free_ext   = 7'(w_free);

    // Lowest free slot among the occupied marks.
    always_comb begin
        w_found = 1'b0;
        w_free  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_occ[i]) begin
                w_found = 1'b1;
                w_free  = SLOT_W'(i);
            end
        end
    end

    // Modify step for the slot whose data was read last cycle.
    tts_slot_update #(
        .TIME_BITS (TIME_BITS)
    ) u_update (
        .i_dispatch (r_is_disp),
        .i_occupied (r_occ[r_idx]),
        .i_delay    (r_rd_data.delay),
        .i_period   (r_rd_data.period),
        .i_pending  (r_rd_data.pending),
        .o_delay    (w_upd_delay),
        .o_pending  (w_upd_pend),
        .o_due      (w_upd_due)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tts_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_in.data.action)
                        tts_pkg::ACT_ADD:    n_state = tts_pkg::ST_ADD_WAIT;
                        tts_pkg::ACT_DELETE: n_state = tts_pkg::ST_IDLE;
                        default:             n_state = tts_pkg::ST_SCAN;
                    endcase
                end
            end
            tts_pkg::ST_SCAN: begin
                if (!w_stall && (r_idx == LAST_IDX)) begin
                    n_state = r_is_disp ? tts_pkg::ST_FLUSH : tts_pkg::ST_IDLE;
                end
            end
            tts_pkg::ST_ADD_WAIT: begin
                if (w_out_free) begin
                    n_state = tts_pkg::ST_IDLE;
                end
            end
            tts_pkg::ST_FLUSH: begin
                if (!r_hold_valid || w_out_free) begin
                    n_state = tts_pkg::ST_IDLE;
                end
            end
            default: n_state = tts_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory port, scan step and output loads.
    always_comb begin
        w_due       = 1'b0;
        w_stall     = 1'b0;
        w_scan_step = 1'b0;
        w_rd_addr   = '0;
        w_we        = 1'b0;
        w_wa        = r_idx;
        w_wd        = r_rd_data;
        w_out_load  = 1'b0;
        w_out_data  = '0;
        case (r_state)
            tts_pkg::ST_IDLE: begin
                if (w_accept && (i_in.data.action == tts_pkg::ACT_ADD) && w_found) begin
                    w_we         = 1'b1;
                    w_wa         = w_free;
                    w_wd.tag     = i_in.data.task_tag;
                    w_wd.delay   = w_delay_ext[TIME_BITS-1:0];
                    w_wd.period  = w_period_ext[TIME_BITS-1:0];
                    w_wd.pending = 8'd0;
                end
            end
            tts_pkg::ST_SCAN: begin
                w_due       = w_upd_due;
                w_stall     = w_upd_due && r_hold_valid && !w_out_free;
                w_scan_step = !w_stall;
                w_rd_addr   = (w_stall || (r_idx == LAST_IDX)) ? r_idx : r_idx + 1'b1;
                w_we        = !w_stall;
                w_wd.delay  = w_upd_delay;
                w_wd.pending = w_upd_pend;
                if (w_upd_due && r_hold_valid && w_out_free) begin
                    w_out_load         = 1'b1;
                    w_out_data.status  = tts_pkg::STAT_DUE;
                    w_out_data.slot    = r_hold_slot;
                    w_out_data.due_tag = r_hold_tag;
                    w_out_data.last    = 1'b0;
                end
            end
            tts_pkg::ST_ADD_WAIT: begin
                if (w_out_free) begin
                    w_out_load         = 1'b1;
                    w_out_data.status  = r_add_status;
                    w_out_data.slot    = r_add_slot;
                    w_out_data.due_tag = 8'd0;
                    w_out_data.last    = 1'b1;
                end
            end
            tts_pkg::ST_FLUSH: begin
                if (r_hold_valid && w_out_free) begin
                    w_out_load         = 1'b1;
                    w_out_data.status  = tts_pkg::STAT_DUE;
                    w_out_data.slot    = r_hold_slot;
                    w_out_data.due_tag = r_hold_tag;
                    w_out_data.last    = 1'b1;
                end
            end
            default: begin
                w_out_load = 1'b0;
            end
        endcase
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tts_pkg::ST_IDLE;
            r_occ        <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_state <= n_state;
            // Occupied marks: add sets, delete clears when in range.
            if (w_accept && (i_in.data.action == tts_pkg::ACT_ADD) && w_found) begin
                r_occ[w_free] <= 1'b1;
            end
            if (w_accept && (i_in.data.action == tts_pkg::ACT_DELETE)
                && (w_del_idx < SLOTS_7)) begin
                r_occ[w_del_idx[SLOT_W-1:0]] <= 1'b0;
            end
            // Scan index.
            if (w_accept) begin
                r_idx <= '0;
            end else if (w_scan_step && (r_idx != LAST_IDX)) begin
                r_idx <= r_idx + 1'b1;
            end
            // Hold stage for the most recent due slot.
            if (w_due && !w_stall) begin
                r_hold_valid <= 1'b1;
            end else if ((r_state == tts_pkg::ST_FLUSH) && w_out_free) begin
                r_hold_valid <= 1'b0;
            end
            // Output register valid.
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_is_disp    <= (i_in.data.action == tts_pkg::ACT_DISPATCH);
            r_add_status <= w_found ? tts_pkg::STAT_ADDED : tts_pkg::STAT_FULL;
            r_add_slot   <= w_found ? w_free_ext[2:0] : 3'd0;
        end
        if (w_due && !w_stall) begin
            r_hold_slot <= w_idx_ext[2:0];
            r_hold_tag  <= r_rd_data.tag;
        end
        if (w_out_load) begin
            r_out <= w_out_data;
        end
    end

    assign i_in.ready  = (r_state == tts_pkg::ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule
